>>> src/csmr_pkg.sv
package csmr_pkg;

    localparam int CFG_W = 10;
    localparam int BLK_W = 5;

    localparam logic [1:0] REG_ROW_WIDTH   = 2'd0;
    localparam logic [1:0] REG_ROW_COUNT   = 2'd1;
    localparam logic [1:0] REG_BLOCK_COUNT = 2'd2;

    localparam int RESET_ROW_WIDTH   = 520;
    localparam int RESET_ROW_COUNT   = 80;
    localparam int RESET_BLOCK_COUNT = 7;

    // Frame geometry as the front end sees it
    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] base;
    } geom_t;

endpackage

>>> src/column_strip_max_reduce_unit.sv
// Channel   Dir  Ports     Contents (low bit first)
// s_axis    in   tdata     depth_sample
// m_axis    out  tdata     strip_index, max_value;  tlast = last_strip
// apb       in   paddr     row_width @0x0, row_count @0x4, block_count @0x8
//
// One sample per cycle; the strip compare and the position counters finish in the
// accepting cycle. The results of a frame leave one per cycle while m_axis_tready
// is high, from a drain bank, with one more frame held in a pending slot;
// s_axis_tready drops while both are occupied. A mapped register write stalls the
// input while the serial divider (one quotient bit per cycle) finds strip widths.
// Reset is synchronous on aresetn low and restores the reset geometry at once.
module column_strip_max_reduce_unit #(
    parameter int MAX_STRIPS    = 16,
    parameter int SAMPLE_BITS   = 16,
    parameter int MAX_ROW_WIDTH = 1024,
    localparam int SIW   = (MAX_STRIPS > 1) ? $clog2(MAX_STRIPS) : 1,
    localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((SIW + SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // depth_sample
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // strip_index, max_value
    output logic             m_axis_tlast,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CW   = csmr_pkg::CFG_W;
    localparam int BW   = csmr_pkg::BLK_W;
    localparam int SCW  = $clog2(MAX_STRIPS + 1);
    localparam int WMAX = (MAX_ROW_WIDTH - 1 > 1023) ? 1023 : MAX_ROW_WIDTH - 1;
    localparam int RST_W = (csmr_pkg::RESET_ROW_WIDTH > WMAX) ? WMAX
                                                               : csmr_pkg::RESET_ROW_WIDTH;
    localparam int RST_B = (csmr_pkg::RESET_BLOCK_COUNT > MAX_STRIPS) ? MAX_STRIPS
                                                                       : csmr_pkg::RESET_BLOCK_COUNT;
    localparam int RST_BASE = RST_W / RST_B;
    localparam int RST_WIDE = RST_W % RST_B;

    logic [CW-1:0]  row_width_reg;
    logic [CW-1:0]  row_count_reg;
    logic [BW-1:0]  block_count_reg;
    logic           start_reg;
    logic           cfg_we;
    logic           cfg_hit;
    logic [1:0]     cfg_idx;
    logic [CW-1:0]  eff_width;
    logic [CW-1:0]  eff_rows;
    logic [7:0]     blk_ext;
    logic [SCW-1:0] eff_strips;
    logic           div_busy;
    logic [CW-1:0]  div_quo;
    logic [SCW-1:0] div_rem;
    csmr_pkg::geom_t geom;
    logic           in_accept;
    logic           push;
    logic           q_full;
    logic [MAX_STRIPS*SAMPLE_BITS-1:0] snap;
    logic [SIW-1:0] out_index;
    logic [SAMPLE_BITS-1:0] out_value;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_hit = cfg_we && (cfg_idx == csmr_pkg::REG_ROW_WIDTH ||
                                cfg_idx == csmr_pkg::REG_ROW_COUNT ||
                                cfg_idx == csmr_pkg::REG_BLOCK_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg   <= CW'(csmr_pkg::RESET_ROW_WIDTH);
            row_count_reg   <= CW'(csmr_pkg::RESET_ROW_COUNT);
            block_count_reg <= BW'(csmr_pkg::RESET_BLOCK_COUNT);
            start_reg       <= 1'b0;
        end else begin
            start_reg <= cfg_hit;
            if (cfg_we) begin
                case (cfg_idx)
                    csmr_pkg::REG_ROW_WIDTH:   row_width_reg   <= pwdata[CW-1:0];
                    csmr_pkg::REG_ROW_COUNT:   row_count_reg   <= pwdata[CW-1:0];
                    csmr_pkg::REG_BLOCK_COUNT: block_count_reg <= pwdata[BW-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (cfg_idx)
            csmr_pkg::REG_ROW_WIDTH:   prdata = 32'(row_width_reg);
            csmr_pkg::REG_ROW_COUNT:   prdata = 32'(row_count_reg);
            csmr_pkg::REG_BLOCK_COUNT: prdata = 32'(block_count_reg);
            default:                   prdata = '0;
        endcase
    end

    // Zero counts act as one; clamp width and strip count to what the hardware holds
    always_comb begin
        if (row_width_reg == '0) begin
            eff_width = CW'(1);
        end else if (row_width_reg > CW'(WMAX)) begin
            eff_width = CW'(WMAX);
        end else begin
            eff_width = row_width_reg;
        end
        eff_rows = (row_count_reg == '0) ? CW'(1) : row_count_reg;
        blk_ext  = 8'(block_count_reg);
        if (blk_ext == '0) begin
            eff_strips = SCW'(1);
        end else if (blk_ext > 8'(MAX_STRIPS)) begin
            eff_strips = SCW'(MAX_STRIPS);
        end else begin
            eff_strips = blk_ext[SCW-1:0];
        end
    end

    csmr_divider #(
        .DVD_W     (CW),
        .DVS_W     (SCW),
        .RESET_QUO (RST_BASE),
        .RESET_REM (RST_WIDE)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start_reg),
        .dividend  (eff_width),
        .divisor   (eff_strips),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign geom.width = eff_width;
    assign geom.rows  = eff_rows;
    assign geom.base  = div_quo;

    assign s_axis_tready = !start_reg && !div_busy && !q_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    csmr_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_STRIPS  (MAX_STRIPS),
        .SIW         (SIW)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (start_reg),
        .geom    (geom),
        .wide    (div_rem[SIW-1:0]),
        .accept  (in_accept),
        .sample  (s_axis_tdata[SAMPLE_BITS-1:0]),
        .push    (push),
        .snap    (snap)
    );

    csmr_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_STRIPS  (MAX_STRIPS),
        .SIW         (SIW),
        .SCW         (SCW)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .snap      (snap),
        .strips    (eff_strips),
        .full      (q_full),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_index (out_index),
        .out_value (out_value),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'({out_value, out_index});

`ifndef NO_ASSERTIONS
    a_frame_unbroken: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("strip results of a frame broke off before the last one");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> out_index == SIW'(eff_strips - 1'b1))
        else $error("last strip flag on the wrong strip index");

    a_cfg_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_hit |=> !s_axis_tready)
        else $error("input taken while strip widths are recomputed");
`endif

endmodule

>>> src/csmr_divider.sv
module csmr_divider #(
    parameter int DVD_W     = 10,
    parameter int DVS_W     = 5,
    parameter int RESET_QUO = 74,
    parameter int RESET_REM = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             ge;

    // One quotient bit per cycle, restoring form
    always_comb begin
        shifted  = {rem_reg, quo_reg[DVD_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        ge       = (shifted >= {1'b0, dvs_reg});
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        if (start) begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = CNT_W'(DVD_W);
        end else if (cnt_reg != '0) begin
            quo_next = {quo_reg[DVD_W-2:0], ge};
            rem_next = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quo_reg <= DVD_W'(RESET_QUO);
            rem_reg <= DVS_W'(RESET_REM);
            dvs_reg <= '0;
            cnt_reg <= '0;
        end else begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            dvs_reg <= dvs_next;
            cnt_reg <= cnt_next;
        end
    end

    assign busy      = (cnt_reg != '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> src/csmr_front.sv
module csmr_front #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_STRIPS  = 16,
    parameter int SIW         = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              restart,
    input  csmr_pkg::geom_t                   geom,
    input  logic [SIW-1:0]                    wide,
    input  logic                              accept,
    input  logic signed [SAMPLE_BITS-1:0]     sample,
    output logic                              push,
    output logic [MAX_STRIPS*SAMPLE_BITS-1:0] snap
);

    localparam int CW = csmr_pkg::CFG_W;
    localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] max_reg  [MAX_STRIPS];
    logic signed [SAMPLE_BITS-1:0] max_next [MAX_STRIPS];
    logic signed [SAMPLE_BITS-1:0] upd      [MAX_STRIPS];
    logic [CW-1:0]  col_reg, col_next;
    logic [CW-1:0]  row_reg, row_next;
    logic [CW-1:0]  off_reg, off_next;
    logic [SIW-1:0] cur_reg, cur_next;
    logic [CW:0]    width_here;
    logic [CW:0]    off_inc;
    logic           col_last;
    logic           row_last;
    logic           frame_end;

    assign col_last  = (col_reg == geom.width - 1'b1);
    assign row_last  = (row_reg == geom.rows - 1'b1);
    assign frame_end = accept && col_last && row_last;
    assign push      = frame_end;

    always_comb begin
        for (int i = 0; i < MAX_STRIPS; i++) begin
            upd[i] = (accept && cur_reg == SIW'(i) && sample > max_reg[i]) ? sample : max_reg[i];
            max_next[i] = (restart || frame_end) ? MOST_NEG : upd[i];
            snap[i*SAMPLE_BITS +: SAMPLE_BITS] = upd[i];
        end
    end

    always_comb begin
        width_here = {1'b0, geom.base} + {{CW{1'b0}}, (cur_reg < wide)};
        off_inc    = {1'b0, off_reg} + 1'b1;
        col_next   = col_reg;
        row_next   = row_reg;
        off_next   = off_reg;
        cur_next   = cur_reg;
        if (restart) begin
            col_next = '0;
            row_next = '0;
            off_next = '0;
            cur_next = '0;
        end else if (accept) begin
            // advance to the next strip once this one is full
            if (off_inc >= width_here) begin
                off_next = '0;
                cur_next = cur_reg + 1'b1;
            end else begin
                off_next = off_inc[CW-1:0];
            end
            if (col_last) begin
                col_next = '0;
                off_next = '0;
                cur_next = '0;
                row_next = row_last ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            off_reg <= '0;
            cur_reg <= '0;
            for (int i = 0; i < MAX_STRIPS; i++) begin
                max_reg[i] <= MOST_NEG;
            end
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            off_reg <= off_next;
            cur_reg <= cur_next;
            for (int i = 0; i < MAX_STRIPS; i++) begin
                max_reg[i] <= max_next[i];
            end
        end
    end

endmodule

>>> src/csmr_back.sv
module csmr_back #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_STRIPS  = 16,
    parameter int SIW         = 4,
    parameter int SCW         = 5
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              push,
    input  logic [MAX_STRIPS*SAMPLE_BITS-1:0] snap,
    input  logic [SCW-1:0]                    strips,
    output logic                              full,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [SIW-1:0]                    out_index,
    output logic [SAMPLE_BITS-1:0]            out_value,
    output logic                              out_last
);

    localparam int SNAP_W = MAX_STRIPS * SAMPLE_BITS;

    logic              pend_valid_reg, pend_valid_next;
    logic [SNAP_W-1:0] pend_reg;
    logic [SNAP_W-1:0] drain_reg, drain_next;
    logic [SCW-1:0]    left_reg, left_next;
    logic [SIW-1:0]    idx_reg, idx_next;
    logic              pop;
    logic              load;

    assign pop  = (left_reg != '0) && out_ready;
    // refill the drain bank when it is empty or on the cycle its last item leaves
    assign load = pend_valid_reg && ((left_reg == '0) || (pop && left_reg == SCW'(1)));

    always_comb begin
        pend_valid_next = pend_valid_reg;
        drain_next      = drain_reg;
        left_next       = left_reg;
        idx_next        = idx_reg;
        // a new frame may land in the slot that is being handed to the drain bank
        if (push) begin
            pend_valid_next = 1'b1;
        end else if (load) begin
            pend_valid_next = 1'b0;
        end
        if (load) begin
            drain_next = pend_reg;
            left_next  = strips;
            idx_next   = '0;
        end else if (pop) begin
            drain_next = drain_reg >> SAMPLE_BITS;
            left_next  = left_reg - 1'b1;
            idx_next   = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            left_reg       <= '0;
            idx_reg        <= '0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            left_reg       <= left_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            pend_reg <= snap;
        end
        drain_reg <= drain_next;
    end

    assign full      = pend_valid_reg && !load;
    assign out_valid = (left_reg != '0);
    assign out_index = idx_reg;
    assign out_value = drain_reg[SAMPLE_BITS-1:0];
    assign out_last  = (left_reg == SCW'(1));

endmodule

>>> sim/column_strip_max_reduce_unit_checker.sv
`timescale 1ns / 100ps

module column_strip_max_reduce_unit_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // depth_sample
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,    // strip_index, max_value, zero pad
    input  logic        m_tlast,    // last_strip
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          outstanding,
    output int          failures,
    output int          results_seen
);

    localparam int MAX_STRIPS = 16;
    localparam logic signed [15:0] DEPTH_FLOOR = 16'sh8000;

    typedef struct packed {
        logic [3:0]  strip;
        logic [15:0] peak;
        logic        last;
    } strip_peak_t;

    // register copies and derived strip geometry
    logic [9:0] row_width_reg;
    logic [9:0] row_count_reg;
    logic [4:0] block_count_reg;
    int         base_w;
    int         wide_n;

    // frame position
    int col;
    int row;
    int cur_strip;
    int in_strip;

    logic signed [15:0] strip_peak [MAX_STRIPS];
    strip_peak_t        pending_peaks [$];

    int fail_tally = 0;
    int seen_tally = 0;

    function automatic int used_width();
        return (row_width_reg == 0) ? 1 : int'(row_width_reg);
    endfunction

    function automatic int used_rows();
        return (row_count_reg == 0) ? 1 : int'(row_count_reg);
    endfunction

    function automatic int used_strips();
        int b;
        b = int'(block_count_reg);
        if (b == 0) b = 1;
        if (b > MAX_STRIPS) b = MAX_STRIPS;
        return b;
    endfunction

    task automatic clear_peaks();
        for (int k = 0; k < MAX_STRIPS; k++) strip_peak[k] = DEPTH_FLOOR;
    endtask

    task automatic restart_frame();
        base_w    = used_width() / used_strips();
        wide_n    = used_width() % used_strips();
        col       = 0;
        row       = 0;
        cur_strip = 0;
        in_strip  = 0;
        clear_peaks();
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
        fail_tally++;
    endtask

    task automatic take_depth(input logic signed [15:0] depth);
        int          span;
        int          n;
        strip_peak_t res;
        if (cur_strip < MAX_STRIPS && depth > strip_peak[cur_strip])
            strip_peak[cur_strip] = depth;
        span = base_w + ((cur_strip < wide_n) ? 1 : 0);
        in_strip++;
        if (in_strip >= span) begin
            in_strip = 0;
            cur_strip++;
        end
        col++;
        if (col >= used_width()) begin
            col       = 0;
            cur_strip = 0;
            in_strip  = 0;
            row++;
            if (row >= used_rows()) begin
                row = 0;
                n   = used_strips();
                for (int k = 0; k < n; k++) begin
                    res.strip = 4'(k);
                    res.peak  = strip_peak[k];
                    res.last  = (k == n - 1);
                    pending_peaks.push_back(res);
                end
                clear_peaks();
            end
        end
    endtask

    task automatic write_register(input logic [3:0] addr, input logic [31:0] data);
        case (addr[3:2])
            csmr_pkg::REG_ROW_WIDTH: begin
                row_width_reg = data[9:0];
                restart_frame();
            end
            csmr_pkg::REG_ROW_COUNT: begin
                row_count_reg = data[9:0];
                restart_frame();
            end
            csmr_pkg::REG_BLOCK_COUNT: begin
                block_count_reg = data[4:0];
                restart_frame();
            end
            default: ;  // unmapped: drop
        endcase
    endtask

    task automatic check_read(input logic [3:0] addr, input logic [31:0] data);
        logic [31:0] want;
        case (addr[3:2])
            csmr_pkg::REG_ROW_WIDTH:   want = {22'b0, row_width_reg};
            csmr_pkg::REG_ROW_COUNT:   want = {22'b0, row_count_reg};
            csmr_pkg::REG_BLOCK_COUNT: want = {27'b0, block_count_reg};
            default:                   return;
        endcase
        if (data !== want) report_mismatch("register read", int'(data), int'(want));
    endtask

    task automatic check_peak();
        strip_peak_t want;
        if (pending_peaks.size() == 0) begin
            report_mismatch("result with nothing pending, strip", int'(m_tdata[3:0]), -1);
            return;
        end
        want = pending_peaks.pop_front();
        seen_tally++;
        if (m_tdata[3:0] !== want.strip)
            report_mismatch("strip_index", int'(m_tdata[3:0]), int'(want.strip));
        if (m_tdata[19:4] !== want.peak)
            report_mismatch("max_value", int'($signed(m_tdata[19:4])), int'($signed(want.peak)));
        if (m_tlast !== want.last)
            report_mismatch("last_strip", int'(m_tlast), int'(want.last));
        if (m_tdata[23:20] !== 4'b0)
            report_mismatch("tdata padding", int'(m_tdata[23:20]), 0);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg   = 10'(csmr_pkg::RESET_ROW_WIDTH);
            row_count_reg   = 10'(csmr_pkg::RESET_ROW_COUNT);
            block_count_reg = 5'(csmr_pkg::RESET_BLOCK_COUNT);
            restart_frame();
            pending_peaks.delete();
        end else begin
            if (m_tvalid && m_tready) check_peak();
            if (psel && penable && pready) begin
                if (pwrite) write_register(paddr, pwdata);
                else        check_read(paddr, prdata);
            end
            if (s_tvalid && s_tready) take_depth($signed(s_tdata));
        end
        outstanding  <= pending_peaks.size();
        failures     <= fail_tally;
        results_seen <= seen_tally;
    end

endmodule

>>> sim/column_strip_max_reduce_unit_test.sv
`timescale 1ns / 100ps

module column_strip_max_reduce_unit_test;

    localparam int IDLE_LIMIT    = 3000;
    localparam int RANDOM_ITEMS  = 78;
    localparam int SETTLE_CYCLES = 20;

    localparam logic [3:0] ADDR_ROW_WIDTH   = {csmr_pkg::REG_ROW_WIDTH, 2'b00};
    localparam logic [3:0] ADDR_ROW_COUNT   = {csmr_pkg::REG_ROW_COUNT, 2'b00};
    localparam logic [3:0] ADDR_BLOCK_COUNT = {csmr_pkg::REG_BLOCK_COUNT, 2'b00};
    localparam logic [3:0] ADDR_UNMAPPED    = 4'hC;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic [15:0] s_data  = 16'h0;
    logic        m_ready = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = 4'h0;
    logic [31:0] pwdata  = 32'h0;

    logic        s_ready;
    logic        m_valid;
    logic [23:0] m_data;
    logic        m_last;
    logic [31:0] prdata;
    logic        pready;

    int outstanding;
    int failures;
    int results_seen;

    bit idle_on        = 1'b0;
    int samples_sent   = 0;
    int settings_made  = 0;
    int cur_w          = csmr_pkg::RESET_ROW_WIDTH;
    int cur_r          = csmr_pkg::RESET_ROW_COUNT;
    int rx_hold        = 0;
    int idle_run       = 0;

    wire any_accept = (s_valid && s_ready) || (m_valid && m_ready)
                    || (psel && penable && pready);

    always #1 aclk = ~aclk;

    column_strip_max_reduce_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tlast  (m_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    column_strip_max_reduce_unit_checker peak_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_valid),
        .s_tready     (s_ready),
        .s_tdata      (s_data),
        .m_tvalid     (m_valid),
        .m_tready     (m_ready),
        .m_tdata      (m_data),
        .m_tlast      (m_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .outstanding  (outstanding),
        .failures     (failures),
        .results_seen (results_seen)
    );

    // mostly short stalls, now and then a long one
    function automatic int stall_len();
        return ($urandom_range(0, 4) != 0) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] next_depth();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(0, 15) - 8);  // near zero, so ties happen
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold--;
        end else if (!idle_on || $urandom_range(0, 1)) begin
            m_ready <= 1'b1;
            rx_hold = $urandom_range(0, 12);
        end else begin
            m_ready <= 1'b0;
            rx_hold = stall_len() - 1;
        end
    end

    initial begin
        while (idle_run < IDLE_LIMIT) begin
            @(posedge aclk);
            if (any_accept) idle_run = 0;
            else            idle_run++;
        end
        $display("column_strip_max_reduce_unit_test: errors");
        $finish;
    end

    // leaves the bus in the access state; the caller releases it
    task automatic apb_access(input logic wr, input logic [3:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    task automatic set_geometry(input int w, input int r, input int b,
                                input logic [2:0] which, input bit readback);
        if (which[0]) begin
            apb_access(1'b1, ADDR_ROW_WIDTH, 32'(w));
            cur_w = w;
        end
        if (which[1]) begin
            apb_access(1'b1, ADDR_ROW_COUNT, 32'(r));
            cur_r = r;
        end
        if (which[2]) apb_access(1'b1, ADDR_BLOCK_COUNT, 32'(b));
        if (readback) begin
            apb_access(1'b0, ADDR_ROW_WIDTH, 32'h0);
            apb_access(1'b0, ADDR_ROW_COUNT, 32'h0);
            apb_access(1'b0, ADDR_BLOCK_COUNT, 32'h0);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        if (which != 3'b000) settings_made++;
    endtask

    task automatic send_depth(input logic [15:0] depth);
        int gap;
        gap = (idle_on && $urandom_range(0, 1)) ? stall_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= depth;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
    endtask

    // drop valid, drain every pending result, then give the datapath time to go quiet
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int          frame_len;
        int          count;
        int          n;
        int          w;
        int          r;
        int          b;
        logic [2:0]  which;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        idle_on = 1'b1;

        // reset geometry: part of a frame, cut short by the first write
        send_depth(16'h7FFF);
        send_depth(16'h8000);
        settle();

        // one sample per frame, one strip
        set_geometry(1, 1, 1, 3'b111, 1'b1);
        send_depth(16'h8000);
        send_depth(16'h7FFF);
        send_depth(16'h0000);
        send_depth(16'hFFFF);
        settle();

        // more strips than columns: the last two never see a sample
        set_geometry(3, 1, 5, 3'b111, 1'b1);
        send_depth(16'h8000);
        send_depth(16'h1234);
        send_depth(16'h7FFF);
        settle();

        // zero registers behave as one
        set_geometry(0, 0, 0, 3'b111, 1'b1);
        send_depth(16'hA5A5);
        settle();

        // strip count saturates; a write to an unmapped address must not restart the frame
        set_geometry(16, 1, 31, 3'b111, 1'b1);
        send_depth(16'h8000);
        send_depth(16'h7FFF);
        send_depth(16'h0000);
        send_depth(16'hFFFF);
        send_depth(16'h0001);
        send_depth(16'h5555);
        send_depth(16'hAAAA);
        send_depth(16'h8001);
        settle();
        apb_access(1'b1, ADDR_UNMAPPED, 32'h3FF);
        set_geometry(0, 0, 0, 3'b000, 1'b1);
        repeat (8) send_depth(next_depth());
        settle();

        // widest row and tallest frame: start a frame, then cut it short
        set_geometry(1023, 1, 16, 3'b111, 1'b0);
        repeat (8) send_depth(next_depth());
        settle();
        set_geometry(1, 1023, 2, 3'b111, 1'b0);
        repeat (8) send_depth(next_depth());
        settle();

        n = 0;
        while (n < RANDOM_ITEMS) begin
            idle_on = ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 9))
                0, 1:    w = $urandom_range(0, 3);
                2:       w = $urandom_range(17, 32);
                default: w = $urandom_range(4, 16);
            endcase
            r = $urandom_range(0, 2);
            b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
            which = 3'($urandom_range(1, 7));
            // leave the wide and tall settings behind so frames stay short
            if (cur_w > 32) which[0] = 1'b1;
            if (cur_r > 2)  which[1] = 1'b1;
            set_geometry(w, r, b, which, $urandom_range(0, 3) == 0);
            frame_len = ((cur_w == 0) ? 1 : cur_w) * ((cur_r == 0) ? 1 : cur_r);
            count = $urandom_range(1, 2) * frame_len;
            // sometimes stop mid-frame so the next write restarts it
            if ($urandom_range(0, 4) == 0) count += $urandom_range(0, frame_len - 1);
            if (count > RANDOM_ITEMS - n) count = RANDOM_ITEMS - n;
            repeat (count) send_depth(next_depth());
            n += count;
            settle();
        end

        $display("covered %0d depth samples under %0d register settings", samples_sent,
                 settings_made);
        $display("compared %0d strip maxima, %0d mismatches", results_seen, failures);
        if (failures == 0) begin
            $display("column_strip_max_reduce_unit_test: clean");
        end else begin
            $display("column_strip_max_reduce_unit_test: errors");
        end
        $finish;
    end

endmodule

>>> sim.f
src/csmr_pkg.sv
src/csmr_divider.sv
src/csmr_front.sv
src/csmr_back.sv
src/column_strip_max_reduce_unit.sv
sim/column_strip_max_reduce_unit_checker.sv
sim/column_strip_max_reduce_unit_test.sv
